// File: hw/rtl/elf64hc_pkg.sv
// Shared types and constants for the ELF64 image header checker.
// No dependencies; every other RTL file of the block imports this package.
`default_nettype none

package elf64hc_pkg;

  // Stream payload widths.
  localparam int unsigned InTdataW  = 392;
  localparam int unsigned OutTdataW = 8;
  localparam int unsigned ImageW    = 64;
  localparam int unsigned TableLenW = 32;

  // Verdict codes carried in the result status field.
  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_TOO_SMALL  = 4'd1,
    ST_BAD_MAGIC  = 4'd2,
    ST_CLASS      = 4'd3,
    ST_ENCODING   = 4'd4,
    ST_MACHINE    = 4'd5,
    ST_TYPE       = 4'd6,
    ST_BAD_HEADER = 4'd7,
    ST_BAD_PHDRS  = 4'd8,
    ST_BAD_LOAD   = 4'd9,
    ST_PENDING    = 4'd10
  } status_e;

  // Record kind carried in tuser.
  localparam logic FuncFileHdr = 1'b0;
  localparam logic FuncProgHdr = 1'b1;

  // ELF identification and header values that are accepted.
  localparam logic [7:0]  Mag0          = 8'h7F;
  localparam logic [7:0]  Mag1          = 8'h45;
  localparam logic [7:0]  Mag2          = 8'h4C;
  localparam logic [7:0]  Mag3          = 8'h46;
  localparam logic [7:0]  Class64       = 8'd2;
  localparam logic [7:0]  DataLsb       = 8'd1;
  localparam logic [7:0]  IdVersion     = 8'd1;
  localparam logic [31:0] VersionCur    = 32'd1;
  localparam logic [15:0] MachX8664     = 16'd62;
  localparam logic [15:0] TypeExec      = 16'd2;
  localparam logic [15:0] TypeDyn       = 16'd3;
  localparam logic [15:0] MinHdrSize    = 16'd64;
  localparam logic [15:0] MinEntrySize  = 16'd56;
  localparam logic [63:0] MinImageSize  = 64'd64;
  localparam logic [31:0] SegTypeLoad   = 32'd1;

  // One unpacked input record.
  typedef struct packed {
    logic        func;
    logic [55:0] ident;
    logic [31:0] version;
    logic [15:0] machine;
    logic [15:0] obj_type;
    logic [15:0] header_size;
    logic [15:0] entry_size;
    logic [15:0] entry_count;
    logic [63:0] offset;
    logic [31:0] seg_type;
    logic [63:0] seg_filesz;
    logic [63:0] seg_memsz;
  } rec_t;

  // Handshake status handed from the result stage back to the input stage.
  typedef struct packed {
    logic out_free;
  } flow_t;

endpackage

`default_nettype wire

// File: hw/rtl/elf64hc_in_reg.sv
// Input register of the ELF64 header checker: unpacks a stream transfer and
// precomputes the program header table length. Depends on elf64hc_pkg.
`default_nettype none

module elf64hc_in_reg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_valid_i,
  output logic                                  s_ready_o,
  input  wire logic [elf64hc_pkg::InTdataW-1:0] s_data_i,
  input  wire logic                             s_user_i,
  input  wire elf64hc_pkg::flow_t               flow_i,
  output logic                                  valid_o,
  output elf64hc_pkg::rec_t                     rec_o,
  output logic [elf64hc_pkg::TableLenW-1:0]     table_len_o
);
  import elf64hc_pkg::*;

  logic                 valid_q, valid_d;
  rec_t                 rec_q, rec_d;
  logic [TableLenW-1:0] table_len_q, table_len_d;
  logic                 load;

  // The stage takes a new record when it is empty or its record moves on.
  assign s_ready_o = !valid_q || flow_i.out_free;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    rec_d.func        = s_user_i;
    rec_d.ident       = s_data_i[55:0];
    rec_d.version     = s_data_i[87:56];
    rec_d.machine     = s_data_i[103:88];
    rec_d.obj_type    = s_data_i[119:104];
    rec_d.header_size = s_data_i[135:120];
    rec_d.entry_size  = s_data_i[151:136];
    rec_d.entry_count = s_data_i[167:152];
    rec_d.offset      = s_data_i[231:168];
    rec_d.seg_type    = s_data_i[263:232];
    rec_d.seg_filesz  = s_data_i[327:264];
    rec_d.seg_memsz   = s_data_i[391:328];
    table_len_d = {16'b0, s_data_i[167:152]} * {16'b0, s_data_i[151:136]};
    valid_d     = load ? 1'b1 : (flow_i.out_free ? 1'b0 : valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rec_q       <= rec_d;
      table_len_q <= table_len_d;
    end
  end

  assign valid_o     = valid_q;
  assign rec_o       = rec_q;
  assign table_len_o = table_len_q;

endmodule

`default_nettype wire

// File: hw/rtl/elf64hc_hdr_check.sv
// File header checks of the ELF64 header checker, in priority order.
// Purely combinational. Depends on elf64hc_pkg.
`default_nettype none

module elf64hc_hdr_check (
  input  wire elf64hc_pkg::rec_t                 rec_i,
  input  wire logic [elf64hc_pkg::TableLenW-1:0] table_len_i,
  input  wire logic [elf64hc_pkg::ImageW-1:0]    image_size_i,
  output elf64hc_pkg::status_e                   status_o
);
  import elf64hc_pkg::*;

  logic [ImageW-1:0] table_len;
  logic              magic_ok, enc_ok, type_ok, size_ok, table_ok;

  always_comb begin
    table_len = {{(ImageW-TableLenW){1'b0}}, table_len_i};
    magic_ok  = rec_i.ident[7:0] == Mag0 && rec_i.ident[15:8] == Mag1 &&
                rec_i.ident[23:16] == Mag2 && rec_i.ident[31:24] == Mag3;
    enc_ok    = rec_i.ident[47:40] == DataLsb && rec_i.ident[55:48] == IdVersion &&
                rec_i.version == VersionCur;
    type_ok   = rec_i.obj_type == TypeExec || rec_i.obj_type == TypeDyn;
    size_ok   = rec_i.header_size >= MinHdrSize && rec_i.entry_size >= MinEntrySize &&
                rec_i.entry_count != 16'd0;
    // The table must fit, and start plus length must stay inside the image.
    table_ok  = table_len <= image_size_i && rec_i.offset <= image_size_i &&
                table_len <= image_size_i - rec_i.offset;

    if (image_size_i < MinImageSize) begin
      status_o = ST_TOO_SMALL;
    end else if (!magic_ok) begin
      status_o = ST_BAD_MAGIC;
    end else if (rec_i.ident[39:32] != Class64) begin
      status_o = ST_CLASS;
    end else if (!enc_ok) begin
      status_o = ST_ENCODING;
    end else if (rec_i.machine != MachX8664) begin
      status_o = ST_MACHINE;
    end else if (!type_ok) begin
      status_o = ST_TYPE;
    end else if (!size_ok) begin
      status_o = ST_BAD_HEADER;
    end else if (!table_ok) begin
      status_o = ST_BAD_PHDRS;
    end else begin
      status_o = ST_PENDING;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/elf64hc_core.sv
// Check state and result register of the ELF64 header checker: tracks the
// program header records of a check and latches the first error. Depends on elf64hc_pkg.
`default_nettype none

module elf64hc_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire elf64hc_pkg::rec_t             rec_i,
  input  wire elf64hc_pkg::status_e          hdr_status_i,
  input  wire logic [elf64hc_pkg::ImageW-1:0] image_size_i,
  output elf64hc_pkg::flow_t                 flow_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output elf64hc_pkg::status_e               out_status_o,
  output logic                               out_done_o
);
  import elf64hc_pkg::*;

  logic [15:0] entries_left_q, entries_left_d;
  logic        load_seen_q, load_seen_d;
  status_e     verdict_q, verdict_d;
  logic        finished_q, finished_d;
  logic        out_valid_q, out_valid_d;
  status_e     out_status_q;
  logic        out_done_q;

  logic        out_free, take;
  logic        is_load, bad_load, seen;
  logic [15:0] dec;

  assign out_free = !out_valid_q || out_ready_i;
  assign take     = in_valid_i && out_free;

  always_comb begin
    entries_left_d = entries_left_q;
    load_seen_d    = load_seen_q;
    verdict_d      = verdict_q;
    finished_d     = finished_q;
    is_load  = rec_i.seg_type == SegTypeLoad;
    bad_load = is_load && (rec_i.seg_filesz > rec_i.seg_memsz ||
               rec_i.offset > image_size_i ||
               rec_i.seg_filesz > image_size_i - rec_i.offset);
    seen     = load_seen_q || is_load;
    dec      = entries_left_q - 16'd1;

    if (take) begin
      if (rec_i.func == FuncFileHdr) begin
        load_seen_d = 1'b0;
        verdict_d   = hdr_status_i;
        if (hdr_status_i == ST_PENDING) begin
          entries_left_d = rec_i.entry_count;
          finished_d     = 1'b0;
        end else begin
          entries_left_d = 16'd0;
          finished_d     = 1'b1;
        end
      end else if (!finished_q) begin
        load_seen_d = seen;
        if (bad_load) begin
          verdict_d      = ST_BAD_LOAD;
          finished_d     = 1'b1;
          entries_left_d = 16'd0;
        end else begin
          entries_left_d = dec;
          if (dec == 16'd0) begin
            verdict_d  = seen ? ST_OK : ST_BAD_LOAD;
            finished_d = 1'b1;
          end
        end
      end
    end

    out_valid_d = take ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_left_q <= 16'd0;
      load_seen_q    <= 1'b0;
      verdict_q      <= ST_OK;
      finished_q     <= 1'b1;
      out_valid_q    <= 1'b0;
    end else begin
      entries_left_q <= entries_left_d;
      load_seen_q    <= load_seen_d;
      verdict_q      <= verdict_d;
      finished_q     <= finished_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_status_q <= verdict_d;
      out_done_q   <= finished_d;
    end
  end

  assign flow_o.out_free = out_free;
  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_done_o      = out_done_q;

endmodule

`default_nettype wire

// File: hw/rtl/elf64_image_header_checker.sv
// ELF64 image header checker, top level. Instantiates the input register, the
// header check logic and the check state with its result register. Depends on elf64hc_pkg.
`default_nettype none

// The checker validates an ELF64 image for a secure loader. Write the image
// length through the configuration channel first, while the block is idle.
// Then send the file header as one transfer with tuser low, followed by one
// transfer per program header record with tuser high. Every input transfer
// produces exactly one result transfer: status in tdata[3:0] and done_res in
// tuser. A file header that passes its checks reports status 10 (pending)
// with done_res low; the last program header record, or the first failing
// one, reports the final verdict with done_res high, and the verdict stays
// latched for any further records until the next file header, which always
// starts a fresh check. The block takes one record per clock cycle while results
// are accepted, and each record passes through the input register, where the
// table length product is formed, and then through the checks that feed the
// result register. Back pressure on the result side stalls the input side only
// when both registers are full. No memory is used and no clearing pass follows
// reset.

module elf64_image_header_checker (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Configuration: image length in bytes.
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [elf64hc_pkg::ImageW-1:0]    cfg_data_i,
  // Records in.
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // From bit 0 up: ident[55:0], version[31:0], machine[15:0], obj_type[15:0],
  // header_size[15:0], entry_size[15:0], entry_count[15:0], offset[63:0],
  // seg_type[31:0], seg_filesz[63:0], seg_memsz[63:0].
  input  wire logic [elf64hc_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // From bit 0 up: func.
  input  wire logic                              s_axis_tuser_i,
  // Results out.
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // From bit 0 up: status[3:0], then four zero bits.
  output logic [elf64hc_pkg::OutTdataW-1:0]      m_axis_tdata_o,
  // From bit 0 up: done_res.
  output logic                                   m_axis_tuser_o
);
  import elf64hc_pkg::*;

  // Image length register; the user must write it only between checks, the block itself does not enforce this.
  logic [ImageW-1:0] image_size_q;

  flow_t                flow;
  logic                 in_valid;
  rec_t                 rec;
  logic [TableLenW-1:0] table_len;
  status_e              hdr_status;
  status_e              out_status;
  logic                 out_done;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_size_q <= '0;
    end else if (cfg_valid_i) begin
      image_size_q <= cfg_data_i;
    end
  end

  elf64hc_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_data_i    (s_axis_tdata_i),
    .s_user_i    (s_axis_tuser_i),
    .flow_i      (flow),
    .valid_o     (in_valid),
    .rec_o       (rec),
    .table_len_o (table_len)
  );

  elf64hc_hdr_check u_hdr_check (
    .rec_i        (rec),
    .table_len_i  (table_len),
    .image_size_i (image_size_q),
    .status_o     (hdr_status)
  );

  elf64hc_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .rec_i        (rec),
    .hdr_status_i (hdr_status),
    .image_size_i (image_size_q),
    .flow_o       (flow),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (out_status),
    .out_done_o   (out_done)
  );

  assign m_axis_tdata_o = {{(OutTdataW-4){1'b0}}, out_status};
  assign m_axis_tuser_o = out_done;

`ifndef NO_ASSERTIONS
  // While a check is open, the only verdict that can be reported is pending.
  a_open_is_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tuser_o) |-> (out_status == ST_PENDING))
    else $error("open check reported a status other than pending");

  // A final verdict is never the pending code.
  a_final_not_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (out_status != ST_PENDING))
    else $error("final verdict reported as pending");

  // A record held in the input register is not dropped while results stall.
  a_in_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && !flow.out_free) |=> in_valid)
    else $error("input record lost during result stall");
`endif

endmodule

`default_nettype wire
